/* hdl/pfe_pkg.sv */
package pfe_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int VALUE_W         = 32;
  localparam int CHAR_W          = 8;
  localparam int CNT_W           = $clog2(VALUE_W);
  localparam int STEP_W          = 4;

  localparam logic [CHAR_W-1:0]  CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0]  CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0]  CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0]  CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0]  CH_SLASH = 8'h2F;
  localparam logic [VALUE_W-1:0] POP_EMPTY_VALUE = 32'd36;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE     = 4'd0;
  localparam step_t ST_DISPATCH = 4'd1;
  localparam step_t ST_POP_R    = 4'd2;
  localparam step_t ST_POP_L    = 4'd3;
  localparam step_t ST_CAP_L    = 4'd4;
  localparam step_t ST_SELECT   = 4'd5;
  localparam step_t ST_ALU      = 4'd6;
  localparam step_t ST_DIV_INIT = 4'd7;
  localparam step_t ST_DIV_STEP = 4'd8;
  localparam step_t ST_DIV_FIX  = 4'd9;
  localparam step_t ST_PUSH     = 4'd10;
  localparam step_t ST_LAST     = 4'd11;
  localparam step_t ST_FIN_POP  = 4'd12;
  localparam step_t ST_FIN_CAP  = 4'd13;
  localparam step_t ST_EMIT     = 4'd14;
  localparam step_t ST_EMIT_RET = 4'd15;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_DIGIT,
    C_NOT_ARITH,
    C_DIV,
    C_DIVZERO,
    C_CNT,
    C_NOT_LAST,
    C_OUT_FREE
  } cond_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_ACCEPT,
    A_DIGIT,
    A_POP,
    A_CAP_R_POP,
    A_CAP_L,
    A_ALU,
    A_DIV_INIT,
    A_DIV_STEP,
    A_DIV_FIX,
    A_PUSH,
    A_CAP_TOP,
    A_EMIT
  } act_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    unique case (step)
      ST_IDLE:     w = '{A_ACCEPT,    C_NO_IN,     ST_IDLE};
      ST_DISPATCH: w = '{A_DIGIT,     C_DIGIT,     ST_PUSH};
      ST_POP_R:    w = '{A_POP,       C_NEVER,     ST_IDLE};
      ST_POP_L:    w = '{A_CAP_R_POP, C_NEVER,     ST_IDLE};
      ST_CAP_L:    w = '{A_CAP_L,     C_NOT_ARITH, ST_LAST};
      ST_SELECT:   w = '{A_NONE,      C_DIV,       ST_DIV_INIT};
      ST_ALU:      w = '{A_ALU,       C_ALWAYS,    ST_PUSH};
      ST_DIV_INIT: w = '{A_DIV_INIT,  C_DIVZERO,   ST_PUSH};
      ST_DIV_STEP: w = '{A_DIV_STEP,  C_CNT,       ST_DIV_STEP};
      ST_DIV_FIX:  w = '{A_DIV_FIX,   C_NEVER,     ST_IDLE};
      ST_PUSH:     w = '{A_PUSH,      C_NEVER,     ST_IDLE};
      ST_LAST:     w = '{A_NONE,      C_NOT_LAST,  ST_IDLE};
      ST_FIN_POP:  w = '{A_POP,       C_NEVER,     ST_IDLE};
      ST_FIN_CAP:  w = '{A_CAP_TOP,   C_NEVER,     ST_IDLE};
      ST_EMIT:     w = '{A_EMIT,      C_OUT_FREE,  ST_IDLE};
      ST_EMIT_RET: w = '{A_NONE,      C_ALWAYS,    ST_EMIT};
      default:     w = '{A_NONE,      C_ALWAYS,    ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* hdl/pfe_if.sv */
interface pfe_in_if;
  import pfe_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface pfe_out_if;
  import pfe_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      underflow;
  logic                      div_by_zero;
  logic                      overflow;

  modport source (output valid, output value, output underflow, output div_by_zero,
                  output overflow, input ready);
  modport sink   (input valid, input value, input underflow, input div_by_zero,
                  input overflow, output ready);
endinterface

/* hdl/pfe_ram.sv */
module pfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/postfix_expression_evaluator.sv */
// Evaluates a postfix expression fed one character word at a time, the last word flagged;
// the result word carries the popped top value and the sticky underflow, divide-by-zero
// and overflow flags, after which the stack and flags are cleared. A small microcode
// table steps a datapath of two operand registers, a combinational multiplier, a
// restoring divider and a stack memory with registered read. A division runs its 32
// single-bit divider iterations; the flagged last word adds a final pop and emit.
// A new word is taken while a finished result still waits on the output register.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  pfe_in_if.sink   in_ch,
  pfe_out_if.source out_ch
);
  import pfe_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int SW = $clog2(STACK_DEPTH + 1);

  ucode_t uc;
  logic   take;

  step_t         pc_r, pc_nxt;
  logic [SW-1:0] sp_r, sp_nxt, sp_dec;
  logic          uf_r, uf_nxt, dz_r, dz_nxt, of_r, of_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [CHAR_W-1:0]  char_r, char_nxt;
  logic               last_r, last_nxt;
  logic               pop_empty_r, pop_empty_nxt;
  logic [VALUE_W-1:0] a_r, a_nxt, b_r, b_nxt, res_r, res_nxt;
  logic [VALUE_W:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic               out_uf_r, out_uf_nxt, out_dz_r, out_dz_nxt, out_of_r, out_of_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;
  logic [VALUE_W-1:0] popped;
  logic [CHAR_W-1:0]  digit;
  logic               is_digit, is_arith, out_free;
  logic [VALUE_W:0]   rem_sh, diff;

  pfe_ram #(.WIDTH(VALUE_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sp_r[AW-1:0]),
    .wdata (res_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign uc        = ucode_rom(pc_r);
  assign sp_dec    = sp_r - SW'(1);
  assign ram_raddr = sp_dec[AW-1:0];
  assign popped    = pop_empty_r ? POP_EMPTY_VALUE : ram_rdata;
  assign digit     = char_r - CH_ZERO;
  assign is_digit  = (char_r >= CH_ZERO) && (char_r <= CH_NINE);
  assign is_arith  = (char_r == CH_PLUS) || (char_r == CH_MINUS) ||
                     (char_r == CH_STAR) || (char_r == CH_SLASH);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign rem_sh    = {rem_r[VALUE_W-1:0], b_r[VALUE_W-1]};
  assign diff      = rem_sh - {1'b0, a_r};

  assign in_ch.ready        = (pc_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.value       = $signed(out_value_r);
  assign out_ch.underflow   = out_uf_r;
  assign out_ch.div_by_zero = out_dz_r;
  assign out_ch.overflow    = out_of_r;

  always_comb begin
    case (uc.cond)
      C_ALWAYS:    take = 1'b1;
      C_NO_IN:     take = !in_ch.valid;
      C_DIGIT:     take = is_digit;
      C_NOT_ARITH: take = !is_arith;
      C_DIV:       take = (char_r == CH_SLASH);
      C_DIVZERO:   take = (a_r == '0);
      C_CNT:       take = (cnt_r != '0);
      C_NOT_LAST:  take = !last_r;
      C_OUT_FREE:  take = out_free;
      default:     take = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt        = take ? uc.target : pc_r + step_t'(1);
    sp_nxt        = sp_r;
    uf_nxt        = uf_r;
    dz_nxt        = dz_r;
    of_nxt        = of_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    char_nxt      = char_r;
    last_nxt      = last_r;
    pop_empty_nxt = pop_empty_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    res_nxt       = res_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    out_value_nxt = out_value_r;
    out_uf_nxt    = out_uf_r;
    out_dz_nxt    = out_dz_r;
    out_of_nxt    = out_of_r;
    ram_we        = 1'b0;

    case (uc.act) inside
      A_ACCEPT: begin
        if (in_ch.valid) begin
          char_nxt = in_ch.char_code;
          last_nxt = in_ch.is_last;
        end
      end
      A_DIGIT: begin
        res_nxt = {{(VALUE_W - CHAR_W){1'b0}}, digit};
      end
      A_POP, A_CAP_R_POP: begin
        if (uc.act == A_CAP_R_POP) begin
          a_nxt = popped;
        end
        pop_empty_nxt = (sp_r == '0);
        if (sp_r == '0) begin
          uf_nxt = 1'b1;
        end else begin
          sp_nxt = sp_dec;
        end
      end
      A_CAP_L, A_CAP_TOP: begin
        b_nxt = popped;
      end
      A_ALU: begin
        case (char_r)
          CH_PLUS:  res_nxt = b_r + a_r;
          CH_MINUS: res_nxt = b_r - a_r;
          default:  res_nxt = b_r * a_r;
        endcase
      end
      A_DIV_INIT: begin
        if (a_r == '0) begin
          res_nxt = '0;
          dz_nxt  = 1'b1;
        end else begin
          neg_nxt = a_r[VALUE_W-1] ^ b_r[VALUE_W-1];
          a_nxt   = a_r[VALUE_W-1] ? -a_r : a_r;
          b_nxt   = b_r[VALUE_W-1] ? -b_r : b_r;
          rem_nxt = '0;
          cnt_nxt = CNT_W'(VALUE_W - 1);
        end
      end
      A_DIV_STEP: begin
        if (!diff[VALUE_W]) begin
          rem_nxt = diff;
          b_nxt   = {b_r[VALUE_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          b_nxt   = {b_r[VALUE_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      A_DIV_FIX: begin
        res_nxt = neg_r ? -b_r : b_r;
      end
      A_PUSH: begin
        if (sp_r == SW'(STACK_DEPTH)) begin
          of_nxt = 1'b1;
        end else begin
          ram_we = 1'b1;
          sp_nxt = sp_r + SW'(1);
        end
      end
      A_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = b_r;
          out_uf_nxt    = uf_r;
          out_dz_nxt    = dz_r;
          out_of_nxt    = of_r;
          sp_nxt        = '0;
          uf_nxt        = 1'b0;
          dz_nxt        = 1'b0;
          of_nxt        = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_IDLE;
      sp_r        <= '0;
      uf_r        <= 1'b0;
      dz_r        <= 1'b0;
      of_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      sp_r        <= sp_nxt;
      uf_r        <= uf_nxt;
      dz_r        <= dz_nxt;
      of_r        <= of_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r      <= char_nxt;
    last_r      <= last_nxt;
    pop_empty_r <= pop_empty_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    res_r       <= res_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    neg_r       <= neg_nxt;
    out_value_r <= out_value_nxt;
    out_uf_r    <= out_uf_nxt;
    out_dz_r    <= out_dz_nxt;
    out_of_r    <= out_of_nxt;
  end

endmodule
